@@ hdl/ikin_pkg.sv @@
`timescale 1ns / 1ps

package ikin_pkg;

    // Defaults for the top-level parameters.
    localparam int COORD_FRAC_BITS_DEF = 4;
    localparam int CORDIC_STAGES_DEF   = 16;

    // Field and register widths.
    localparam int COORD_W    = 12;
    localparam int LINK_W     = 8;
    localparam int REACH_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int SHOULDER_W = 16;
    localparam int ELBOW_W    = 15;
    localparam int OUT_DATA_W = 32;

    // Scaled law-of-cosines denominator 2*l1*l2*256 needs this many bits.
    localparam int D_W = 2 * LINK_W + 9;

    // Angle arithmetic in units of 1/65536 centidegree.
    localparam int ANG_W       = 32;
    localparam int FRAC_SHIFT  = 16;
    localparam int ROUND_HALF  = 32768;
    localparam int CDEG_180    = 18000;
    localparam int CDEG_360    = 36000;
    localparam logic signed [ANG_W-1:0] ANG_180 = 32'sd1179648000;

    // Vectoring front end: magnitudes are normalized into [2^40, 2^41).
    localparam int NORM_W     = 41;
    localparam int NORM_STEPS = 6;
    localparam int ATAN_TAB_N = 24;

    // Register reset values.
    localparam logic [LINK_W-1:0]  UPPER_LINK_RST = 8'd120;
    localparam logic [LINK_W-1:0]  LOWER_LINK_RST = 8'd135;
    localparam logic [REACH_W-1:0] MIN_REACH_RST  = 9'd100;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UPPER_LINK = 2'd0,
        REG_LOWER_LINK = 2'd1,
        REG_MIN_REACH  = 2'd2
    } cfg_reg_t;

    // Arctangent of 2^-i in 1/65536 centidegree.
    function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:       v = 32'sd294912000;
            1:       v = 32'sd174096719;
            2:       v = 32'sd91987927;
            3:       v = 32'sd46694507;
            4:       v = 32'sd23437865;
            5:       v = 32'sd11730358;
            6:       v = 32'sd5866610;
            7:       v = 32'sd2933484;
            8:       v = 32'sd1466764;
            9:       v = 32'sd733385;
            10:      v = 32'sd366693;
            11:      v = 32'sd183347;
            12:      v = 32'sd91673;
            13:      v = 32'sd45837;
            14:      v = 32'sd22918;
            15:      v = 32'sd11459;
            16:      v = 32'sd5730;
            17:      v = 32'sd2865;
            18:      v = 32'sd1432;
            19:      v = 32'sd716;
            20:      v = 32'sd358;
            21:      v = 32'sd179;
            22:      v = 32'sd90;
            23:      v = 32'sd45;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Register stages from the operand inputs of ikin_atan2 to its result.
    function automatic int atan_latency(input int stages);
        return NORM_STEPS + stages + 2;
    endfunction

endpackage

@@ hdl/ikin_isqrt.sv @@
`timescale 1ns / 1ps

// Pipelined integer square root, one result bit per stage.
module ikin_isqrt #(
    parameter int RAD_W = 50
) (
    input  logic               clk,
    input  logic               en,
    input  logic [RAD_W-1:0]   rad,
    output logic [RAD_W/2-1:0] root
);

    localparam int K   = RAD_W / 2;
    localparam int R_W = RAD_W + 1;

    logic [RAD_W-1:0] v_reg [1:K];
    logic [R_W-1:0]   r_reg [1:K];

    for (genvar i = 0; i < K; i++) begin : g_step
        localparam logic [R_W-1:0] BIT = R_W'(1) << (2 * (K - 1 - i));

        logic [RAD_W-1:0] v_in;
        logic [R_W-1:0]   r_in;
        logic [R_W-1:0]   trial;

        if (i == 0) begin : g_first
            assign v_in = rad;
            assign r_in = '0;
        end
        else begin : g_next
            assign v_in = v_reg[i];
            assign r_in = r_reg[i];
        end

        assign trial = r_in + BIT;

        // Restoring step: take the trial value off the remainder when it fits.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if ({1'b0, v_in} >= trial)
                begin
                    v_reg[i+1] <= v_in - trial[RAD_W-1:0];
                    r_reg[i+1] <= (r_in >> 1) + BIT;
                end
                else
                begin
                    v_reg[i+1] <= v_in;
                    r_reg[i+1] <= r_in >> 1;
                end
            end
        end
    end

    assign root = r_reg[K][K-1:0];

endmodule

@@ hdl/ikin_atan2.sv @@
`timescale 1ns / 1ps

// Pipelined atan2 for a nonnegative y and an x of either sign.
// The result lies in [0, 180 degrees], in 1/65536 centidegree.
module ikin_atan2 #(
    parameter int IN_W   = 12,
    parameter int STAGES = 16
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [IN_W-1:0]                 ym,
    input  logic signed [IN_W:0]            xv,
    output logic signed [ikin_pkg::ANG_W-1:0] ang
);

    import ikin_pkg::*;

    localparam int XW = NORM_W + 3;

    typedef struct packed {
        logic neg;
        logic spec;
        logic zero;
    } atan_flags_t;

    atan_flags_t              fl_reg [0:NORM_STEPS+STAGES];
    logic [NORM_W-1:0]        nx_reg [0:NORM_STEPS];
    logic [NORM_W-1:0]        ny_reg [0:NORM_STEPS];
    logic [NORM_W-1:0]        nm_reg [0:NORM_STEPS];
    logic signed [XW-1:0]     cx_reg [1:STAGES];
    logic signed [XW-1:0]     cy_reg [1:STAGES];
    logic signed [ANG_W-1:0]  cz_reg [1:STAGES];
    logic signed [ANG_W-1:0]  ang_reg;

    logic [IN_W:0]     xabs;
    logic [NORM_W-1:0] xe;
    logic [NORM_W-1:0] ye;
    atan_flags_t       fl_next;
    logic signed [ANG_W-1:0] q1;

    // Fold x into the first quadrant and note the special cases.
    always_comb
    begin
        xabs         = xv[IN_W] ? (IN_W+1)'(-xv) : xv;
        xe           = NORM_W'(xabs);
        ye           = NORM_W'(ym);
        fl_next.neg  = xv[IN_W];
        fl_next.spec = xv[IN_W] && (ym == '0);
        fl_next.zero = (xabs == '0) && (ym == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fl_reg[0] <= fl_next;
            nx_reg[0] <= xe;
            ny_reg[0] <= ye;
            nm_reg[0] <= (xe > ye) ? xe : ye;
        end
    end

    // Normalize: binary search of the left shift that brings the larger
    // magnitude into the top bit, one power of two per stage.
    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int SH = 1 << (NORM_STEPS - 1 - j);

        logic room;
        assign room = (nm_reg[j] >> (NORM_W - SH)) == '0;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                fl_reg[j+1] <= fl_reg[j];
                if (room)
                begin
                    nx_reg[j+1] <= nx_reg[j] << SH;
                    ny_reg[j+1] <= ny_reg[j] << SH;
                    nm_reg[j+1] <= nm_reg[j] << SH;
                end
                else
                begin
                    nx_reg[j+1] <= nx_reg[j];
                    ny_reg[j+1] <= ny_reg[j];
                    nm_reg[j+1] <= nm_reg[j];
                end
            end
        end
    end

    // Vectoring rotations, one per stage.
    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        logic signed [XW-1:0]    xi;
        logic signed [XW-1:0]    yi;
        logic signed [XW-1:0]    dx;
        logic signed [XW-1:0]    dy;
        logic signed [ANG_W-1:0] zi;

        if (i == 0) begin : g_first
            assign xi = $signed(XW'(nx_reg[NORM_STEPS]));
            assign yi = $signed(XW'(ny_reg[NORM_STEPS]));
            assign zi = '0;
        end
        else begin : g_next
            assign xi = cx_reg[i];
            assign yi = cy_reg[i];
            assign zi = cz_reg[i];
        end

        assign dx = yi >>> i;
        assign dy = xi >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                fl_reg[NORM_STEPS+1+i] <= fl_reg[NORM_STEPS+i];
                if (!yi[XW-1])
                begin
                    cx_reg[i+1] <= xi + dx;
                    cy_reg[i+1] <= yi - dy;
                    cz_reg[i+1] <= zi + atan_entry(i);
                end
                else
                begin
                    cx_reg[i+1] <= xi - dx;
                    cy_reg[i+1] <= yi + dy;
                    cz_reg[i+1] <= zi - atan_entry(i);
                end
            end
        end
    end

    // Unfold the quadrant: a negative x mirrors the angle about 90 degrees.
    assign q1 = fl_reg[NORM_STEPS+STAGES].zero ? '0 : cz_reg[STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (fl_reg[NORM_STEPS+STAGES].spec)
            begin
                ang_reg <= ANG_180;
            end
            else if (fl_reg[NORM_STEPS+STAGES].neg)
            begin
                ang_reg <= ANG_180 - q1;
            end
            else
            begin
                ang_reg <= q1;
            end
        end
    end

    assign ang = ang_reg;

endmodule

@@ hdl/two_link_inverse_kinematics.sv @@
`timescale 1ns / 1ps
// Throughput: one target per cycle while s_tready is high; every stage, the square
// root and the three atan2 units are fully pipelined, and a two-entry output buffer
// holds results. s_tready drops only when both output buffer entries are full.
// Reset: rst_n clears all valid bits; link registers get 120 and 135, min reach 100.
module two_link_inverse_kinematics #(
    parameter int COORD_FRAC_BITS = ikin_pkg::COORD_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = ikin_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: target_x [11:0], target_y [23:12]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [2*ikin_pkg::COORD_W-1:0]    s_tdata,
    // m_tdata: shoulder_angle [15:0], elbow_angle [30:16], zero [31]
    // m_tuser: reachable [0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ikin_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ikin_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ikin_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import ikin_pkg::*;

    localparam int F2       = 2 * COORD_FRAC_BITS;
    localparam int SH_R     = (F2 >= 8) ? F2 - 8 : 0;
    localparam int SH_L     = (F2 >= 8) ? 0 : 8 - F2;
    localparam int D2_W     = 2 * COORD_W + 1;
    localparam int D8_W     = D2_W + SH_L;
    localparam int NR_W     = D8_W + 2;
    localparam int LS9_W    = (LINK_W + 1 > REACH_W) ? LINK_W + 1 : REACH_W;
    localparam int RB_W     = 2 * LS9_W + F2;
    localparam int CMP_W    = (RB_W > D2_W) ? RB_W : D2_W;
    localparam int C_W      = 2 * LINK_W + 9;
    localparam int N_W      = D_W + 1;
    localparam int RAD_W    = 2 * D_W;
    localparam int S_W      = D_W;
    localparam int LS_W     = LINK_W + S_W;
    localparam int PA_W     = LINK_W + D_W;
    localparam int PB_W     = LINK_W + 1 + N_W;
    localparam int T_W      = LINK_W + D_W + 2;
    localparam int SUM_W    = ANG_W + 1;
    localparam int RND_W    = SUM_W - FRAC_SHIFT;
    localparam int SQRT_LAT = RAD_W / 2;
    localparam int ATAN_LAT = atan_latency(CORDIC_STAGES);

    typedef struct packed {
        logic                  reach;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic signed [N_W-1:0] n;
    } ikin_side_t;

    // Configuration and values derived from it.
    logic [LINK_W-1:0]  upper_reg;
    logic [LINK_W-1:0]  lower_reg;
    logic [REACH_W-1:0] minr_reg;
    logic [RB_W-1:0]    rmax_reg;
    logic [RB_W-1:0]    rmin_reg;
    logic [C_W-1:0]     csum_reg;
    logic [D_W-1:0]     dlen_reg;
    logic [LS9_W-1:0]   lsum;

    // Pipeline control.
    logic en;
    logic push;
    logic pop;

    // Front stages.
    logic                   v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic [COORD_W-1:0]     x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic [2*COORD_W-1:0]   xx1_reg, yy1_reg;
    logic [D2_W-1:0]        d2_reg;
    logic                   reach3_reg;
    logic signed [NR_W-1:0] nraw3_reg;
    ikin_side_t             sb4_reg, sb5_reg, sb6_reg;
    logic [D_W-1:0]         nabs4_reg;
    logic [RAD_W-1:0]       dd5_reg, nn5_reg, rad6_reg;

    logic signed [NR_W-1:0] dext;
    logic signed [N_W-1:0]  ncl_next;
    logic [D_W-1:0]         nabs_next;
    logic [D8_W-1:0]        d8;

    // Square-root alignment line.
    logic                   sq_vld_reg [1:SQRT_LAT];
    ikin_side_t             sq_sb_reg  [1:SQRT_LAT];
    logic [S_W-1:0]         root;

    // Offset operands.
    logic                   p1_vld_reg, p2_vld_reg;
    ikin_side_t             p1_sb_reg;
    logic [S_W-1:0]         p1_s_reg, p2_s_reg;
    logic [LS_W-1:0]        p1_ls_reg, p2_ls_reg;
    logic [PA_W-1:0]        p1_pa_reg;
    logic signed [PB_W-1:0] p1_pb_reg;
    logic                   p2_reach_reg;
    logic [COORD_W-1:0]     p2_x_reg, p2_y_reg;
    logic signed [N_W-1:0]  p2_n_reg;
    logic signed [T_W-1:0]  p2_t_reg;

    // Angle alignment line and final stage.
    logic                    at_vld_reg   [1:ATAN_LAT];
    logic                    at_reach_reg [1:ATAN_LAT];
    logic signed [ANG_W-1:0] base_ang, elb_ang, off_ang;
    logic signed [ANG_W-1:0] elb_rnd;
    logic                    f_vld_reg, f_reach_reg;
    logic signed [SUM_W-1:0] f_sum_reg;
    logic [ELBOW_W-1:0]      f_elbow_reg;
    logic signed [SUM_W-1:0] sum_rnd;
    logic signed [RND_W-1:0] sh_rnd;
    logic signed [RND_W-1:0] sh_wrap;
    logic [OUT_DATA_W-1:0]   push_data;
    logic                    push_user;

    // Output buffer: head register and one spare entry.
    logic                  hd_vld_reg, sp_vld_reg;
    logic [OUT_DATA_W-1:0] hd_data_reg, sp_data_reg;
    logic                  hd_user_reg, sp_user_reg;

    assign cfg_ready = 1'b1;
    assign en        = ~sp_vld_reg;
    assign s_tready  = en;
    assign push      = f_vld_reg & en;
    assign pop       = hd_vld_reg & m_tready;
    assign m_tvalid  = hd_vld_reg;
    assign m_tdata   = hd_data_reg;
    assign m_tuser   = hd_user_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= UPPER_LINK_RST;
            lower_reg <= LOWER_LINK_RST;
            minr_reg  <= MIN_REACH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_UPPER_LINK: upper_reg <= cfg_data[LINK_W-1:0];
                REG_LOWER_LINK: lower_reg <= cfg_data[LINK_W-1:0];
                REG_MIN_REACH:  minr_reg  <= cfg_data[REACH_W-1:0];
                default:        ;
            endcase
        end
    end

    // Workspace bounds and law-of-cosines constants, refreshed every cycle.
    assign lsum = LS9_W'(upper_reg) + LS9_W'(lower_reg);

    always_ff @(posedge clk)
    begin
        rmax_reg <= RB_W'((2*LS9_W)'(lsum) * (2*LS9_W)'(lsum)) << F2;
        rmin_reg <= RB_W'((2*LS9_W)'(minr_reg) * (2*LS9_W)'(minr_reg)) << F2;
        csum_reg <= (C_W'(upper_reg) * C_W'(upper_reg)
                     + C_W'(lower_reg) * C_W'(lower_reg)) << 8;
        dlen_reg <= (D_W'(upper_reg) * D_W'(lower_reg)) << 9;
    end

    // Valid bits of all pipeline stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg     <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
            v5_reg     <= 1'b0;
            v6_reg     <= 1'b0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            f_vld_reg  <= 1'b0;
            for (int k = 1; k <= SQRT_LAT; k++)
            begin
                sq_vld_reg[k] <= 1'b0;
            end
            for (int k = 1; k <= ATAN_LAT; k++)
            begin
                at_vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v0_reg        <= s_tvalid;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            sq_vld_reg[1] <= v6_reg;
            for (int k = 2; k <= SQRT_LAT; k++)
            begin
                sq_vld_reg[k] <= sq_vld_reg[k-1];
            end
            p1_vld_reg    <= sq_vld_reg[SQRT_LAT];
            p2_vld_reg    <= p1_vld_reg;
            at_vld_reg[1] <= p2_vld_reg;
            for (int k = 2; k <= ATAN_LAT; k++)
            begin
                at_vld_reg[k] <= at_vld_reg[k-1];
            end
            f_vld_reg     <= at_vld_reg[ATAN_LAT];
        end
    end

    // Elbow numerator clamped to [-D, D], and its magnitude.
    always_comb
    begin
        d8   = D8_W'(d2_reg >> SH_R) << SH_L;
        dext = $signed(NR_W'(dlen_reg));
        if (nraw3_reg > dext)
        begin
            ncl_next = N_W'(dext);
        end
        else if (nraw3_reg < -dext)
        begin
            ncl_next = N_W'(-dext);
        end
        else
        begin
            ncl_next = N_W'(nraw3_reg);
        end
        nabs_next = ncl_next[N_W-1] ? D_W'(-ncl_next) : D_W'(ncl_next);
    end

    // Front stages: squares, reach test, numerator, radicand.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg     <= s_tdata[COORD_W-1:0];
            y0_reg     <= s_tdata[2*COORD_W-1:COORD_W];

            x1_reg     <= x0_reg;
            y1_reg     <= y0_reg;
            xx1_reg    <= (2*COORD_W)'(x0_reg) * (2*COORD_W)'(x0_reg);
            yy1_reg    <= (2*COORD_W)'(y0_reg) * (2*COORD_W)'(y0_reg);

            x2_reg     <= x1_reg;
            y2_reg     <= y1_reg;
            d2_reg     <= D2_W'(xx1_reg) + D2_W'(yy1_reg);

            x3_reg     <= x2_reg;
            y3_reg     <= y2_reg;
            reach3_reg <= (CMP_W'(d2_reg) >= CMP_W'(rmin_reg))
                          && (CMP_W'(d2_reg) <= CMP_W'(rmax_reg));
            nraw3_reg  <= $signed(NR_W'(d8)) - $signed(NR_W'(csum_reg));

            sb4_reg.reach <= reach3_reg;
            sb4_reg.x     <= x3_reg;
            sb4_reg.y     <= y3_reg;
            sb4_reg.n     <= ncl_next;
            nabs4_reg     <= nabs_next;

            sb5_reg    <= sb4_reg;
            dd5_reg    <= RAD_W'(dlen_reg) * RAD_W'(dlen_reg);
            nn5_reg    <= RAD_W'(nabs4_reg) * RAD_W'(nabs4_reg);

            sb6_reg    <= sb5_reg;
            rad6_reg   <= dd5_reg - nn5_reg;
        end
    end

    ikin_isqrt #(
        .RAD_W (RAD_W)
    ) u_isqrt (
        .clk  (clk),
        .en   (en),
        .rad  (rad6_reg),
        .root (root)
    );

    // Side data travels beside the square root.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_sb_reg[1] <= sb6_reg;
            for (int k = 2; k <= SQRT_LAT; k++)
            begin
                sq_sb_reg[k] <= sq_sb_reg[k-1];
            end
        end
    end

    // Offset vector: (l2*S, l1*D + l2*N).
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_sb_reg    <= sq_sb_reg[SQRT_LAT];
            p1_s_reg     <= root;
            p1_ls_reg    <= LS_W'(lower_reg) * LS_W'(root);
            p1_pa_reg    <= PA_W'(upper_reg) * PA_W'(dlen_reg);
            p1_pb_reg    <= $signed({1'b0, lower_reg}) * sq_sb_reg[SQRT_LAT].n;

            p2_reach_reg <= p1_sb_reg.reach;
            p2_x_reg     <= p1_sb_reg.x;
            p2_y_reg     <= p1_sb_reg.y;
            p2_n_reg     <= p1_sb_reg.n;
            p2_s_reg     <= p1_s_reg;
            p2_ls_reg    <= p1_ls_reg;
            p2_t_reg     <= $signed(T_W'(p1_pa_reg)) + T_W'(p1_pb_reg);
        end
    end

    ikin_atan2 #(
        .IN_W   (COORD_W),
        .STAGES (CORDIC_STAGES)
    ) u_atan_base (
        .clk (clk),
        .en  (en),
        .ym  (p2_y_reg),
        .xv  ($signed({1'b0, p2_x_reg})),
        .ang (base_ang)
    );

    ikin_atan2 #(
        .IN_W   (S_W),
        .STAGES (CORDIC_STAGES)
    ) u_atan_elbow (
        .clk (clk),
        .en  (en),
        .ym  (p2_s_reg),
        .xv  (p2_n_reg),
        .ang (elb_ang)
    );

    ikin_atan2 #(
        .IN_W   (T_W - 1),
        .STAGES (CORDIC_STAGES)
    ) u_atan_offset (
        .clk (clk),
        .en  (en),
        .ym  ((T_W-1)'(p2_ls_reg)),
        .xv  (p2_t_reg),
        .ang (off_ang)
    );

    // Reach flag travels beside the atan2 units.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            at_reach_reg[1] <= p2_reach_reg;
            for (int k = 2; k <= ATAN_LAT; k++)
            begin
                at_reach_reg[k] <= at_reach_reg[k-1];
            end
        end
    end

    // Shoulder sum and elbow rounding.
    assign elb_rnd = (elb_ang + ANG_W'(ROUND_HALF)) >>> FRAC_SHIFT;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reach_reg <= at_reach_reg[ATAN_LAT];
            f_sum_reg   <= SUM_W'(base_ang) + SUM_W'(off_ang);
            f_elbow_reg <= elb_rnd[ELBOW_W-1:0];
        end
    end

    // Round the shoulder to centidegrees and wrap it into (-180, 180].
    always_comb
    begin
        sum_rnd = (f_sum_reg + SUM_W'(ROUND_HALF)) >>> FRAC_SHIFT;
        sh_rnd  = sum_rnd[RND_W-1:0];
        if (sh_rnd > RND_W'(CDEG_180))
        begin
            sh_wrap = sh_rnd - RND_W'(CDEG_360);
        end
        else
        begin
            sh_wrap = sh_rnd;
        end
        if (f_reach_reg)
        begin
            push_data = {1'b0, f_elbow_reg, sh_wrap[SHOULDER_W-1:0]};
        end
        else
        begin
            push_data = '0;
        end
        push_user = f_reach_reg;
    end

    // Output buffer control: the spare entry catches a result while the head stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hd_vld_reg <= 1'b0;
            sp_vld_reg <= 1'b0;
        end
        else if (pop || !hd_vld_reg)
        begin
            if (sp_vld_reg)
            begin
                hd_vld_reg <= 1'b1;
                sp_vld_reg <= push;
            end
            else
            begin
                hd_vld_reg <= push;
            end
        end
        else if (push)
        begin
            sp_vld_reg <= 1'b1;
        end
    end

    // Output buffer data.
    always_ff @(posedge clk)
    begin
        if (pop || !hd_vld_reg)
        begin
            if (sp_vld_reg)
            begin
                hd_data_reg <= sp_data_reg;
                hd_user_reg <= sp_user_reg;
                sp_data_reg <= push_data;
                sp_user_reg <= push_user;
            end
            else
            begin
                hd_data_reg <= push_data;
                hd_user_reg <= push_user;
            end
        end
        else if (push)
        begin
            sp_data_reg <= push_data;
            sp_user_reg <= push_user;
        end
    end

endmodule

@@ hdl/ikin_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks on the result stream.
module ikin_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ikin_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tuser
);

    import ikin_pkg::*;

    localparam logic signed [SHOULDER_W-1:0] SH_MAX = SHOULDER_W'(CDEG_180);

    // A stalled result stays on the bus unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An unreachable target carries zero angles.
    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("unreachable target with nonzero angles");

    // The elbow angle stays within half a turn.
    a_elbow_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[SHOULDER_W +: ELBOW_W] <= ELBOW_W'(CDEG_180))
        else $error("elbow angle out of range");

    // The shoulder angle is wrapped into one turn around zero.
    a_shoulder_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[SHOULDER_W-1:0]) <= SH_MAX)
                     && ($signed(m_tdata[SHOULDER_W-1:0]) > -SH_MAX))
        else $error("shoulder angle out of range");

    // The fill bit above the elbow angle is always zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DATA_W-1] == 1'b0)
        else $error("fill bit set");

endmodule

bind two_link_inverse_kinematics ikin_checker u_ikin_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
